// ----- design/lr_pkg.sv -----
package lr_pkg;

  // Fixed field widths
  localparam int unsigned FIELD_BITS     = 16;
  localparam int unsigned COORD_BITS_MAX = 24;
  localparam int unsigned COLOR_BITS     = 32;
  localparam int unsigned FRAME_BITS     = 14;
  localparam int unsigned PIX_BITS       = 13;

  // Frame size limits
  localparam logic [FRAME_BITS-1:0] FRAME_MAX          = 14'd8192;
  localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = 14'd4480;
  localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = 14'd2520;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // Item actions
  typedef enum logic [0:0] {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef struct packed {
    logic                   action;
    logic signed [15:0]     x_start;
    logic signed [15:0]     x_end;
    logic signed [15:0]     y_start;
    logic signed [15:0]     y_end;
    logic [COLOR_BITS-1:0]  color_start;
    logic [COLOR_BITS-1:0]  color_end;
  } item_t;

  typedef struct packed {
    logic [PIX_BITS-1:0]    pixel_x;
    logic [PIX_BITS-1:0]    pixel_y;
    logic [COLOR_BITS-1:0]  pixel_color;
    logic                   last_pixel;
  } pixel_t;

endpackage

// ----- design/lr_clamp.sv -----
module lr_clamp #(
  parameter int VW = 17
) (
  input  logic signed [VW-1:0]          value,
  input  logic [lr_pkg::FRAME_BITS-1:0] size,
  output logic [lr_pkg::PIX_BITS-1:0]   clamped
);
  import lr_pkg::*;

  localparam int CW = (VW > FRAME_BITS) ? VW : FRAME_BITS;

  logic [PIX_BITS-1:0] lim;
  logic [CW-1:0]       mag;
  logic [CW-1:0]       lim_w;

  // Bring the frame size into 1..8192 and take the last index
  always_comb begin
    priority if (size == '0) begin
      lim = '0;
    end else if (size > FRAME_MAX) begin
      lim = PIX_BITS'(FRAME_MAX - 14'd1);
    end else begin
      lim = PIX_BITS'(size - 14'd1);
    end
  end

  assign mag   = CW'($unsigned(CW'(value)));
  assign lim_w = CW'(lim);

  // Pin negatives to zero and overshoot to the last index
  always_comb begin
    priority if (value < 0) begin
      clamped = '0;
    end else if (mag > lim_w) begin
      clamped = lim;
    end else begin
      clamped = mag[PIX_BITS-1:0];
    end
  end

endmodule

// ----- design/line_rasterizer_top.sv -----
// A pixel item is registered on the output in the cycle after its step item is taken.
// Throughput: one item per cycle unless output stalls; single add-compare walk update.
// Start items and steps with no line in progress give no pixel item.
// The output register frees item_ready whenever it is empty or being drained.
// Reset (rst, synchronous) drops any line in progress, empties the output register and
// returns the frame size to 4480 by 2520.
module line_rasterizer_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  lr_pkg::item_t                 item,
  output logic                          pixel_valid,
  input  logic                          pixel_ready,
  output lr_pkg::pixel_t                pixel,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  lr_pkg::reg_index_t            cfg_index,
  input  logic [lr_pkg::FRAME_BITS-1:0] cfg_data
);
  import lr_pkg::*;

  localparam int P = COORD_BITS + 1;
  localparam int E = COORD_BITS + 3;

  function automatic logic signed [P-1:0] coord_in(input logic [FIELD_BITS-1:0] f);
    logic [COORD_BITS_MAX-1:0] raw;
    raw = {{(COORD_BITS_MAX - FIELD_BITS){1'b0}}, f};
    return {raw[COORD_BITS-1], raw[COORD_BITS-1:0]};
  endfunction

  // Configuration and walk state
  logic [FRAME_BITS-1:0] frame_width;
  logic [FRAME_BITS-1:0] frame_height;
  logic                  line_active;
  logic signed [P-1:0]   major_pos;
  logic signed [P-1:0]   minor_pos;
  logic signed [P-1:0]   major_stop;
  logic signed [P-1:0]   color_switch_point;
  logic signed [E-1:0]   error_term;
  logic signed [P-1:0]   delta_major;
  logic signed [P-1:0]   delta_minor;
  logic                  minor_direction;
  logic                  steep_line;
  logic [COLOR_BITS-1:0] color_now;
  logic [COLOR_BITS-1:0] color_later;

  logic take;

  // Start item set-up
  logic signed [P-1:0]   xa, xb, ya, yb;
  logic signed [P-1:0]   dx, dy;
  logic [P-1:0]          adx, ady;
  logic                  steep_next;
  logic signed [P-1:0]   ma, mb, na, nb;
  logic signed [P-1:0]   sa, sb, ta, tb;
  logic [COLOR_BITS-1:0] ca, cb;
  logic                  swap;
  logic signed [P-1:0]   dmaj_next, dmin_raw, dmin_next;

  // Step item
  logic signed [P-1:0]   px, py;
  logic signed [P-1:0]   major_inc;
  logic                  last;
  logic [PIX_BITS-1:0]   clamp_x, clamp_y;
  logic signed [E-1:0]   err_diag, err_flat;

  assign take       = item_valid && item_ready;
  assign item_ready = !pixel_valid || pixel_ready;
  assign cfg_ready  = 1'b1;

  // Pick the walk direction and order the endpoints
  always_comb begin
    xa  = coord_in(item.x_start);
    xb  = coord_in(item.x_end);
    ya  = coord_in(item.y_start);
    yb  = coord_in(item.y_end);
    dx  = xb - xa;
    dy  = yb - ya;
    adx = (dx < 0) ? $unsigned(-dx) : $unsigned(dx);
    ady = (dy < 0) ? $unsigned(-dy) : $unsigned(dy);
    steep_next = !(ady < adx);
    if (steep_next) begin
      ma = ya; mb = yb; na = xa; nb = xb;
    end else begin
      ma = xa; mb = xb; na = ya; nb = yb;
    end
    swap = ma > mb;
    sa = swap ? mb : ma;
    sb = swap ? ma : mb;
    ta = swap ? nb : na;
    tb = swap ? na : nb;
    ca = swap ? item.color_end : item.color_start;
    cb = swap ? item.color_start : item.color_end;
    dmaj_next = sb - sa;
    dmin_raw  = tb - ta;
    dmin_next = (dmin_raw < 0) ? -dmin_raw : dmin_raw;
  end

  // Current pixel and error updates
  assign px        = steep_line ? minor_pos : major_pos;
  assign py        = steep_line ? major_pos : minor_pos;
  assign major_inc = major_pos + P'(1);
  assign last      = major_inc == major_stop;
  assign err_diag  = error_term + ((E'(delta_minor) - E'(delta_major)) <<< 1);
  assign err_flat  = error_term + (E'(delta_minor) <<< 1);

  lr_clamp #(.VW(P)) u_clamp_x (
    .value   (px),
    .size    (frame_width),
    .clamped (clamp_x)
  );

  lr_clamp #(.VW(P)) u_clamp_y (
    .value   (py),
    .size    (frame_height),
    .clamped (clamp_y)
  );

  // Hold frame size
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load or advance the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (take) begin
      if (item.action == ACT_START) begin
        steep_line         <= steep_next;
        delta_major        <= dmaj_next;
        delta_minor        <= dmin_next;
        minor_direction    <= dmin_raw < 0;
        major_pos          <= sa;
        minor_pos          <= ta;
        major_stop         <= sb;
        color_switch_point <= sa + (dmaj_next >>> 1);
        error_term         <= (E'(dmin_next) <<< 1) - E'(dmaj_next);
        color_now          <= ca;
        color_later        <= cb;
        line_active        <= dmaj_next > 0;
      end else if (line_active) begin
        if (error_term > 0) begin
          minor_pos  <= minor_direction ? minor_pos - P'(1) : minor_pos + P'(1);
          error_term <= err_diag;
        end else begin
          error_term <= err_flat;
        end
        major_pos <= major_inc;
        if (major_inc > color_switch_point) begin
          color_now <= color_later;
        end
        if (last) begin
          line_active <= 1'b0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (take) begin
      pixel_valid <= (item.action == ACT_STEP) && line_active;
    end else if (pixel_ready) begin
      pixel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pixel.pixel_x     <= clamp_x;
      pixel.pixel_y     <= clamp_y;
      pixel.pixel_color <= color_now;
      pixel.last_pixel  <= last;
    end
  end

endmodule

// ----- design/lr_checker.sv -----
module lr_checker (
  input logic           clk,
  input logic           rst,
  input logic           item_valid,
  input logic           item_ready,
  input logic           pixel_valid,
  input logic           pixel_ready,
  input lr_pkg::pixel_t pixel
);
  import lr_pkg::*;

  // Output register is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !pixel_valid)
    else $error("pixel item present after reset");

  // A stalled pixel item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel))
    else $error("stalled pixel item changed or dropped");

  // An empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !pixel_valid |-> item_ready)
    else $error("input stalled with empty output");

  // A new pixel item only follows an accepted item
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_valid) |-> $past(item_valid && item_ready))
    else $error("pixel item without an accepted item");

endmodule

bind line_rasterizer_top lr_checker u_lr_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item_valid),
  .item_ready  (item_ready),
  .pixel_valid (pixel_valid),
  .pixel_ready (pixel_ready),
  .pixel       (pixel)
);
